// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on clk_i and rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true outside reset.
`define SPA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/spa_pkg.sv =====
// Types and constants of the spectrum profile averager.
// No dependencies.
`default_nettype none

package spa_pkg;

  localparam logic [1:0] OP_SRC   = 2'd0;
  localparam logic [1:0] OP_DECAY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [8:0]  COUNT_SAT  = 9'h100;
  localparam logic [8:0]  READY_AT   = 9'd8;
  localparam logic [3:0]  RANK_MIN   = 4'd8;
  localparam logic [3:0]  RANK_RESET = 4'd12;
  localparam logic [23:0] MAG_MAX    = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic               chan;
    logic [12:0]        bin;
    logic signed [23:0] re_part;
    logic signed [23:0] im_part;
    logic               frame_end;
  } in_t;

  typedef struct packed {
    logic        out_chan;
    logic [12:0] out_bin;
    logic [23:0] avg_mag;
    logic [8:0]  frames_done;
    logic        ready_res;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/spectrum_profile_averager.sv =====
// Spectrum profile averager: magnitude, cumulative mean per channel and bin.
// Depends on spa_pkg and assert_macros.svh.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+--------------------------
//   input   | in_valid_i  | in_ready_o  | in_item_i  (spa_pkg::in_t)
//   result  | out_valid_o | out_ready_i | out_item_o (spa_pkg::out_t)
//   config  | cfg_valid_i | cfg_ready_o | cfg_data_i (active rank)
//
// One item per cycle sustained while neither the interlock nor a stalled result holds the input.
// The profile RAM is read as an item leaves fm_q[NSQ] and written back from dm_q[NDV].
// An item whose entry is still in flight waits at the RAM read port until the
// earlier write lands; items for other entries never trigger this interlock.
// A stalled result freezes the whole pipeline. Reset clears count, flag and valid bits and sets rank to RANK_RESET.
`default_nettype none

module spectrum_profile_averager #(
  parameter int CHANNELS = 2,
  parameter int RANK_MAX = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spa_pkg::in_t  in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spa_pkg::out_t      out_item_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [3:0]    cfg_data_i
);

  localparam int STRIDE = (2 ** (RANK_MAX - 1)) + 1;
  localparam int DEPTH  = CHANNELS * STRIDE;
  localparam int IW     = $clog2(DEPTH);
  localparam int CW     = (RANK_MAX > 13) ? RANK_MAX : 14;
  localparam logic [3:0] RANK_TOP = 4'(RANK_MAX);
  localparam int NSQ    = 12;  // sqrt stages, two root bits each
  localparam int NDV    = 13;  // divide stages, two quotient bits each

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          chan;
    logic [12:0]   bin;
    logic          decay;
    logic [8:0]    cnt;    // frame count seen by this item (n - 1)
    logic [8:0]    done;
    logic          rdy;
    logic          last;
  } meta_t;

  typedef struct packed {
    logic [25:0] rem;
    logic [23:0] root;
    logic [47:0] rad;
  } sq_t;

  typedef struct packed {
    logic [8:0]  rem;
    logic [25:0] dv;
    logic [25:0] q;
  } dv_t;

  // one restoring square root step
  function automatic sq_t sq_step(sq_t s);
    logic [27:0] t;
    logic [27:0] tr;
    sq_t r;
    t = {s.rem, s.rad[47:46]};
    tr = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[45:0], 2'b00};
    if (t >= tr) begin
      r.rem  = 26'(t - tr);
      r.root = {s.root[22:0], 1'b1};
    end else begin
      r.rem  = t[25:0];
      r.root = {s.root[22:0], 1'b0};
    end
    return r;
  endfunction

  // one restoring divide step, divisor n
  function automatic dv_t dv_step(dv_t s, logic [8:0] n);
    logic [9:0] t;
    dv_t r;
    t = {s.rem, s.dv[25]};
    r.dv = {s.dv[24:0], 1'b0};
    if (t >= {1'b0, n}) begin
      r.rem = 9'(t - {1'b0, n});
      r.q   = {s.q[24:0], 1'b1};
    end else begin
      r.rem = t[8:0];
      r.q   = {s.q[24:0], 1'b0};
    end
    return r;
  endfunction

  // ---------------- control ----------------
  logic adv, fa, hazard, accept;
  logic [3:0] rank_q;
  logic [8:0] count_q, count_d;
  logic       flag_q, flag_d;

  // pipeline registers
  logic        fv_q [NSQ+1];
  meta_t       fm_q [NSQ+1];
  logic [47:0] sre_q, sim_q;
  sq_t         sd_q [1:NSQ];
  logic        bv_q;
  meta_t       bm_q;
  logic [23:0] bmag_q;
  logic [23:0] rd_q;
  logic        cv_q;
  meta_t       cm_q;
  logic [33:0] acc_q;
  logic        dvv_q [1:NDV];
  meta_t       dm_q [1:NDV];
  dv_t         dd_q [1:NDV];
  logic        out_v_q;
  spa_pkg::out_t out_q;

  logic [23:0] prof_mem [DEPTH];

  assign adv         = !out_v_q || out_ready_i;
  assign fa          = adv && !hazard;
  assign in_ready_o  = fa;
  assign accept      = in_valid_i && fa;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // interlock: same entry still between RAM read and write-back
  always_comb begin
    hazard = 1'b0;
    if (fv_q[NSQ]) begin
      if (bv_q && bm_q.idx == fm_q[NSQ].idx) hazard = 1'b1;
      if (cv_q && cm_q.idx == fm_q[NSQ].idx) hazard = 1'b1;
      for (int k = 1; k <= NDV; k++) begin
        if (dvv_q[k] && dm_q[k].idx == fm_q[NSQ].idx) hazard = 1'b1;
      end
    end
  end

  // ---------------- input decode ----------------
  logic [3:0]    rank_c;
  logic [CW-1:0] limit_c;
  logic          in_ok, enter;
  logic [8:0]    next_cnt;
  meta_t         meta_in;
  logic signed [47:0] pre, pim;

  always_comb begin
    if (rank_q < spa_pkg::RANK_MIN) begin
      rank_c = spa_pkg::RANK_MIN;
    end else if (rank_q > RANK_TOP) begin
      rank_c = RANK_TOP;
    end else begin
      rank_c = rank_q;
    end
    limit_c  = CW'(1) << (rank_c - 4'd1);
    in_ok    = (CW'(in_item_i.bin) <= limit_c) &&
               ((CHANNELS > 1) || !in_item_i.chan);
    next_cnt = (count_q == spa_pkg::COUNT_SAT) ? spa_pkg::COUNT_SAT : count_q + 9'd1;
    count_d  = count_q;
    flag_d   = flag_q;
    enter    = 1'b0;
    if (accept) begin
      case (in_item_i.op)
        spa_pkg::OP_CLEAR: begin
          count_d = '0;
          flag_d  = 1'b0;
        end
        spa_pkg::OP_SRC, spa_pkg::OP_DECAY: begin
          enter = in_ok;
          if (in_item_i.frame_end) begin
            count_d = next_cnt;
            flag_d  = flag_q || (next_cnt >= spa_pkg::READY_AT);
          end
        end
        default: ;
      endcase
    end
    meta_in.idx   = IW'(in_item_i.bin) + (in_item_i.chan ? IW'(STRIDE) : IW'(0));
    meta_in.chan  = in_item_i.chan;
    meta_in.bin   = in_item_i.bin;
    meta_in.decay = (in_item_i.op == spa_pkg::OP_DECAY);
    meta_in.cnt   = count_q;
    meta_in.done  = count_d;
    meta_in.rdy   = flag_d;
    meta_in.last  = in_item_i.frame_end;
  end

  assign pre = in_item_i.re_part * in_item_i.re_part;
  assign pim = in_item_i.im_part * in_item_i.im_part;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= spa_pkg::RANK_RESET;
      count_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) rank_q <= cfg_data_i;
      count_q <= count_d;
      flag_q  <= flag_d;
    end
  end

  // ---------------- magnitude pipeline ----------------
  sq_t sq_init;
  always_comb begin
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.rad  = sre_q + sim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NSQ; k++) fv_q[k] <= 1'b0;
    end else if (fa) begin
      fv_q[0] <= enter;
      for (int k = 1; k <= NSQ; k++) fv_q[k] <= fv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fa) begin
      fm_q[0] <= meta_in;
      sre_q   <= pre;
      sim_q   <= pim;
      for (int k = 1; k <= NSQ; k++) fm_q[k] <= fm_q[k-1];
      sd_q[1] <= sq_step(sq_step(sq_init));
      for (int k = 2; k <= NSQ; k++) sd_q[k] <= sq_step(sq_step(sd_q[k-1]));
    end
  end

  // ---------------- RAM read, weighting, divide ----------------
  logic [23:0] old_c;
  logic [33:0] acc_c;
  dv_t         dv_init;
  logic [25:0] quo;
  logic [23:0] res_c;

  always_comb begin
    old_c = (bm_q.cnt != '0) ? rd_q : '0;
    acc_c = 34'(old_c) * 34'(bm_q.cnt) + 34'((bm_q.cnt + 9'd1) >> 1)
          + (bm_q.decay ? 34'd0 : 34'(bmag_q));
    dv_init.rem = {1'b0, acc_q[33:26]};
    dv_init.dv  = acc_q[25:0];
    dv_init.q   = '0;
    quo   = dd_q[NDV].q;
    res_c = (|quo[25:24]) ? spa_pkg::MAG_MAX : quo[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= 1'b0;
      cv_q    <= 1'b0;
      for (int k = 1; k <= NDV; k++) dvv_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      bv_q     <= fv_q[NSQ] && !hazard;
      cv_q     <= bv_q;
      dvv_q[1] <= cv_q;
      for (int k = 2; k <= NDV; k++) dvv_q[k] <= dvv_q[k-1];
      out_v_q  <= dvv_q[NDV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q   <= prof_mem[fm_q[NSQ].idx];
      bm_q   <= fm_q[NSQ];
      bmag_q <= sd_q[NSQ].root;
      cm_q   <= bm_q;
      acc_q  <= acc_c;
      dm_q[1] <= cm_q;
      dd_q[1] <= dv_step(dv_step(dv_init, cm_q.cnt + 9'd1), cm_q.cnt + 9'd1);
      for (int k = 2; k <= NDV; k++) begin
        dm_q[k] <= dm_q[k-1];
        dd_q[k] <= dv_step(dv_step(dd_q[k-1], dm_q[k-1].cnt + 9'd1),
                           dm_q[k-1].cnt + 9'd1);
      end
      out_q.out_chan    <= dm_q[NDV].chan;
      out_q.out_bin     <= dm_q[NDV].bin;
      out_q.avg_mag     <= res_c;
      out_q.frames_done <= dm_q[NDV].done;
      out_q.ready_res   <= dm_q[NDV].rdy;
      out_q.last        <= dm_q[NDV].last;
      if (dvv_q[NDV]) prof_mem[dm_q[NDV].idx] <= res_c;
    end
  end

  // ---------------- assertions ----------------
`include "assert_macros.svh"

  `SPA_NEVER(a_count_range, count_q > spa_pkg::COUNT_SAT, "frame count above saturation")
  `SPA_NEVER(a_rw_clash, adv && fa && fv_q[NSQ] && dvv_q[NDV] && dm_q[NDV].idx == fm_q[NSQ].idx, "read and write of one entry in the same cycle")
  `SPA_ASSERT(a_no_dup, bv_q && cv_q |-> bm_q.idx != cm_q.idx, "same entry twice in flight")
  `SPA_ASSERT(a_out_hold, out_v_q && !out_ready_i |=> out_v_q && $stable(out_q), "stalled result changed")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for spectrum_profile_averager: random and directed bins,
// predicted cumulative-mean profile compared against every result item.
// Depends on spa_pkg and the averager RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int NCHAN     = 2;
  localparam int RANK_TOP  = 13;
  localparam int STALL_CAP = 5000;  // cycles with no handshake anywhere
  localparam int DRAIN     = 40;    // pipeline depth plus margin

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  spa_pkg::in_t  in_item = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  spa_pkg::out_t out_item;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [3:0]    cfg_data = spa_pkg::RANK_RESET;

  spectrum_profile_averager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted state of the block
  logic [23:0] prof_mag [NCHAN][4097];
  bit          prof_wr  [NCHAN][4097];
  int unsigned frame_cnt;
  bit          ready_flg;
  logic [3:0]  rank_reg;

  spa_pkg::in_t  bins_pending[$];   // items waiting to be offered
  spa_pkg::out_t avg_expected[$];   // predicted result items, oldest first

  int  n_accepted, n_checked, n_mismatch, n_cfg;
  bit  idle_on = 1'b1;     // random bubbles on both sides
  bit  hold_rx = 1'b0;     // long receiver back-pressure

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned bin_limit();
    int unsigned r;
    r = rank_reg;
    if (r < spa_pkg::RANK_MIN) r = spa_pkg::RANK_MIN;
    if (r > RANK_TOP) r = RANK_TOP;
    return 1 << (r - 1);
  endfunction

  function automatic void close_frame();
    frame_cnt = (frame_cnt + 1 > spa_pkg::COUNT_SAT) ? spa_pkg::COUNT_SAT : frame_cnt + 1;
    if (frame_cnt >= spa_pkg::READY_AT) ready_flg = 1'b1;
  endfunction

  // Queue one item for the driver and advance the predicted profile; queue its result, if any.
  task automatic push_bin(spa_pkg::in_t it);
    longint signed   re, im;
    longint unsigned n, prev, acc, mag, res;
    spa_pkg::out_t   r;
    bins_pending.push_back(it);
    if (it.op == spa_pkg::OP_CLEAR) begin
      frame_cnt = 0;
      ready_flg = 1'b0;
      return;
    end
    if (it.op != spa_pkg::OP_SRC && it.op != spa_pkg::OP_DECAY) return;
    if (it.chan >= NCHAN || it.bin > bin_limit()) begin
      if (it.frame_end) close_frame();
      return;
    end
    n = frame_cnt + 1;
    prev = (n > 1) ? prof_mag[it.chan][it.bin] : 0;
    acc = prev * (n - 1) + (n >> 1);
    if (it.op == spa_pkg::OP_SRC) begin
      re = it.re_part;
      im = it.im_part;
      mag = int_sqrt(longint'(re * re) + longint'(im * im));
      if (mag > spa_pkg::MAG_MAX) mag = spa_pkg::MAG_MAX;
      acc += mag;
    end
    res = acc / n;
    if (res > spa_pkg::MAG_MAX) res = spa_pkg::MAG_MAX;
    prof_mag[it.chan][it.bin] = res[23:0];
    prof_wr[it.chan][it.bin] = 1'b1;
    if (it.frame_end) close_frame();
    r.out_chan    = it.chan;
    r.out_bin     = it.bin;
    r.avg_mag     = res[23:0];
    r.frames_done = frame_cnt[8:0];
    r.ready_res   = ready_flg;
    r.last        = it.frame_end;
    avg_expected.push_back(r);
  endtask

  task automatic add_bin(logic [1:0] op, logic ch, int bn, int re, int im, bit fe);
    spa_pkg::in_t it;
    it.op = op;
    it.chan = ch;
    it.bin = bn[12:0];
    it.re_part = re[23:0];
    it.im_part = im[23:0];
    it.frame_end = fe;
    push_bin(it);
  endtask

  function automatic int rand_part();
    case ($urandom_range(0, 7))
      0: return -8388608;
      1: return 8388607;
      default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
    endcase
  endfunction

  // One random item. Once a frame is closed only already-written entries
  // may be updated; untouched ones are reached only with the count at zero.
  task automatic add_random(int fe_odds);
    int unsigned lim, pick, bn, k;
    logic [1:0]  op;
    logic        ch;
    bit          found;
    lim = bin_limit();
    pick = $urandom_range(0, 99);
    if (pick < 70) op = spa_pkg::OP_SRC;
    else if (pick < 88) op = spa_pkg::OP_DECAY;
    else if (pick < 89) op = spa_pkg::OP_CLEAR;
    else if (pick < 91) op = spa_pkg::OP_NONE;
    else op = ($urandom_range(0, 1) != 0) ? spa_pkg::OP_SRC : spa_pkg::OP_DECAY;
    ch = 1'($urandom);
    found = 1'b0;
    bn = 0;
    if (pick >= 91) begin
      bn = $urandom_range(lim + 1, 8191);
      found = 1'b1;
    end else if (frame_cnt == 0) begin
      case ($urandom_range(0, 7))
        0: bn = 0;
        1: bn = lim;
        default: bn = $urandom_range(0, lim > 40 ? 40 : lim);
      endcase
      found = 1'b1;
    end else begin
      for (k = 0; k < 20 && !found; k++) begin
        bn = $urandom_range(0, lim > 40 ? 40 : lim);
        if ($urandom_range(0, 5) == 0) bn = lim;
        if (prof_wr[ch][bn]) found = 1'b1;
      end
    end
    if (!found) bn = $urandom_range(lim + 1, 8191);
    add_bin(op, ch, bn, rand_part(), rand_part(), $urandom_range(0, fe_odds - 1) == 0);
  endtask

  task automatic wait_idle();
    while (bins_pending.size() != 0 || avg_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_rank(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rank_reg = v;
    n_cfg++;
  endtask

  // Input driver: valid held until accepted, bubbles in random bursts.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          void'(bins_pending.pop_front());
          n_accepted++;
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (bins_pending.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= bins_pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  int out_gap = 0;
  always @(posedge clk_i) begin
    spa_pkg::out_t ex;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (avg_expected.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result item: %p", out_item);
        end else begin
          ex = avg_expected.pop_front();
          n_checked++;
          if (out_item.out_chan != ex.out_chan || out_item.out_bin != ex.out_bin ||
              out_item.avg_mag != ex.avg_mag || out_item.frames_done != ex.frames_done ||
              out_item.ready_res != ex.ready_res || out_item.last != ex.last) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: expected %p actual %p", ex, out_item);
          end
        end
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long stall on the result side while items keep coming, to fill the pipe.
  initial begin
    wait (n_accepted >= 300);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // Watchdog: no handshake on any channel for too long.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else if (++quiet >= STALL_CAP) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [3:0] ranks [8];
    int p, i;
    ranks = '{4'd8, 4'd13, 4'd0, 4'd15, 4'd9, 4'd12, 4'd11, 4'd13};
    frame_cnt = 0;
    ready_flg = 1'b0;
    rank_reg = spa_pkg::RANK_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every op, out-of-range bins, clear.
    add_bin(spa_pkg::OP_SRC,   1'b0, 0,    8388607,  8388607,  1'b0);
    add_bin(spa_pkg::OP_SRC,   1'b1, 2048, -8388608, -8388608, 1'b0);
    add_bin(spa_pkg::OP_SRC,   1'b0, 1,    0,        0,        1'b0);
    add_bin(spa_pkg::OP_SRC,   1'b1, 3,    -8388608, 8388607,  1'b0);
    add_bin(spa_pkg::OP_DECAY, 1'b0, 2,    5000,     5000,     1'b0);
    add_bin(spa_pkg::OP_NONE,  1'b0, 5,    1,        1,        1'b1);
    add_bin(spa_pkg::OP_SRC,   1'b0, 2049, 123,      456,      1'b0);
    add_bin(spa_pkg::OP_SRC,   1'b1, 8191, -1,       -1,       1'b1);  // closes frame
    add_bin(spa_pkg::OP_SRC,   1'b0, 0,    0,        -8388608, 1'b0);
    add_bin(spa_pkg::OP_DECAY, 1'b1, 2048, 0,        0,        1'b1);
    add_bin(spa_pkg::OP_CLEAR, 1'b0, 0,    0,        0,        1'b1);
    add_bin(spa_pkg::OP_SRC,   1'b0, 7,    300000,   -400000,  1'b1);
    add_bin(spa_pkg::OP_DECAY, 1'b1, 3,    0,        0,        1'b0);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      write_rank(ranks[p]);
      if (p == 1) begin
        // many short frames: count saturation and the ready flag
        add_bin(spa_pkg::OP_CLEAR, 1'b0, 0, 0, 0, 1'b0);
        for (i = 0; i < 40; i++) add_random(1000);
        for (i = 0; i < 280; i++) add_random(1);
      end else begin
        if (p == 7) idle_on = 1'b0;
        for (i = 0; i < 90; i++) add_random(8);
      end
      wait_idle();
    end

    $display("covered %0d items, %0d results checked, %0d rank writes",
             n_accepted, n_checked, n_cfg);
    if (n_mismatch == 0 && avg_expected.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
